// File: src/deq_pkg.sv
`timescale 1ns / 1ps
// deq_pkg: shared types and constants of the double-ended queue.
// Used by deq_cell, double_ended_queue and deq_checker.
package deq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_e;

  // one-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_op_t;

endpackage

// File: src/double_ended_queue.sv
`timescale 1ns / 1ps
// double_ended_queue: top level, a row of deq_cell stages with command and result logic.
// Depends on deq_pkg and deq_cell.
//
// Usage: each input word carries func_i (push front, push back, pop front,
// pop back) and push_value_i on a valid/ready channel. Each accepted word
// yields exactly one result word on the output valid/ready channel: the
// popped value, the front and back values, the occupancy, an empty flag and
// a status code (done, pop on empty ignored, push on full dropped).
// Words are held left-aligned in a row of DEPTH cells; pushes and pops at
// the front shift the whole row by one cell, pushes and pops at the back
// touch only the cell at the boundary. The back word is found by the cell
// that sees an empty neighbour on its right.
// Order of events: the row, the popped value and the status are registered on
// acceptance, and the result is then copied from them into the output
// register, which drives out_valid_o. One word is in flight at a time: a new
// word is taken only once the previous result has moved to the output register.
// When the receiver stalls, the result is held in the output register and
// a further word is accepted but its result waits until the register frees.
// Reset empties the queue and drops any pending result.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic signed [deq_pkg::WordW-1:0]  push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [deq_pkg::WordW-1:0]  popped_value_o,
  output logic signed [deq_pkg::WordW-1:0]  front_value_o,
  output logic signed [deq_pkg::WordW-1:0]  back_value_o,
  output logic [deq_pkg::OccW-1:0]          occupancy_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);
  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                    cell_valid [DEPTH];
  logic signed [WordW-1:0] cell_value [DEPTH];
  logic signed [WordW-1:0] cell_tap   [DEPTH];

  cell_op_t                op;
  logic                    accept, full, empty;
  logic signed [WordW-1:0] back_word;
  logic signed [WordW-1:0] popped_d;
  status_e                 status_d;

  logic                    busy_q, busy_d;
  logic [CntW-1:0]         count_q, count_d;
  logic signed [WordW-1:0] popped_q;
  status_e                 status_q;

  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic signed [WordW-1:0] out_popped_q, out_front_q, out_back_q;
  logic [OccW-1:0]         out_occ_q;
  logic                    out_empty_q;
  status_e                 out_status_q;
  logic [CntW+OccW-1:0]    count_ext;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = ~busy_q;
  assign full       = cell_valid[DEPTH-1];
  assign empty      = ~cell_valid[0];

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tap[i];
    end
  end

  always_comb begin
    op       = '0;
    popped_d = '0;
    status_d = STATUS_DONE;
    count_d  = count_q;
    case (func_e'(func_i))
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_PUSH_FULL;
        end else begin
          op.push_front = accept & (func_e'(func_i) == FUNC_PUSH_FRONT);
          op.push_back  = accept & (func_e'(func_i) == FUNC_PUSH_BACK);
          count_d       = count_q + CntW'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_POP_EMPTY;
        end else begin
          op.pop_front = accept;
          popped_d     = cell_value[0];
          count_d      = count_q - CntW'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_POP_EMPTY;
        end else begin
          op.pop_back = accept;
          popped_d    = back_word;
          count_d     = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = STATUS_DONE;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    lv, rv;
    logic signed [WordW-1:0] lw, rw;
    if (g == 0) begin : g_head
      assign lv = 1'b1;
      assign lw = push_value_i;
    end else begin : g_mid_l
      assign lv = cell_valid[g-1];
      assign lw = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rw = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[g+1];
      assign rw = cell_value[g+1];
    end
    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .push_value_i  (push_value_i),
      .left_valid_i  (lv),
      .left_value_i  (lw),
      .right_valid_i (rv),
      .right_value_i (rw),
      .valid_o       (cell_valid[g]),
      .value_o       (cell_value[g]),
      .tap_o         (cell_tap[g])
    );
  end

  assign out_load  = busy_q & (~out_valid_q | out_ready_i);
  assign count_ext = {{OccW{1'b0}}, count_q};

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
    if (out_load) begin
      out_popped_q <= popped_q;
      out_front_q  <= empty ? '0 : cell_value[0];
      out_back_q   <= back_word;
      out_occ_q    <= count_ext[OccW-1:0];
      out_empty_q  <= empty;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_popped_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;
  assign occupancy_o    = out_occ_q;
  assign is_empty_o     = out_empty_q;
  assign status_o       = out_status_q;

endmodule

// File: src/deq_cell.sv
`timescale 1ns / 1ps
// deq_cell: one storage cell of the queue row, holding a word and its valid flag.
// Depends on deq_pkg; instantiated in a row by double_ended_queue.
module deq_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  deq_pkg::cell_op_t                   op_i,
  input  logic signed [deq_pkg::WordW-1:0]    push_value_i,
  input  logic                                left_valid_i,
  input  logic signed [deq_pkg::WordW-1:0]    left_value_i,
  input  logic                                right_valid_i,
  input  logic signed [deq_pkg::WordW-1:0]    right_value_i,
  output logic                                valid_o,
  output logic signed [deq_pkg::WordW-1:0]    value_o,
  output logic signed [deq_pkg::WordW-1:0]    tap_o
);
  import deq_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [WordW-1:0] value_q, value_d;
  logic                    is_last;

  assign is_last = valid_q & ~right_valid_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (op_i.push_front) begin
      valid_d = left_valid_i;
      value_d = left_value_i;
    end else if (op_i.push_back) begin
      if (!valid_q && left_valid_i) begin
        valid_d = 1'b1;
        value_d = push_value_i;
      end
    end else if (op_i.pop_front) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end else if (op_i.pop_back) begin
      if (is_last) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign tap_o   = is_last ? value_q : '0;

endmodule

// File: src/deq_checker.sv
`timescale 1ns / 1ps
// deq_checker: port-level assertions for double_ended_queue, bound to the top level.
// Depends on deq_pkg.
module deq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [deq_pkg::WordW-1:0]  popped_value_o,
  input logic signed [deq_pkg::WordW-1:0]  front_value_o,
  input logic signed [deq_pkg::WordW-1:0]  back_value_o,
  input logic [deq_pkg::OccW-1:0]          occupancy_o,
  input logic                              is_empty_o,
  input logic [1:0]                        status_o
);
  import deq_pkg::*;

  // one word in flight: ready drops after every accepted word
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted while another is in flight");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> occupancy_o == '0 && front_value_o == '0
      && back_value_o == '0)
    else $error("empty queue shows stored words");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_POP_EMPTY |-> popped_value_o == '0 && is_empty_o)
    else $error("ignored pop reports a word or a non-empty queue");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_PUSH_FULL |-> !is_empty_o && popped_value_o == '0)
    else $error("dropped push reports an empty queue or a popped word");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .popped_value_o (popped_value_o),
  .front_value_o  (front_value_o),
  .back_value_o   (back_value_o),
  .occupancy_o    (occupancy_o),
  .is_empty_o     (is_empty_o),
  .status_o       (status_o)
);
